// ===== rtl/cluster_bbox_centroid_filter_macros.svh =====
// assertion macros for the cluster bounding box and centroid filter
// no dependencies; included by cbcf_ctrl, the module that carries assertions
`ifndef CLUSTER_BBOX_CENTROID_FILTER_MACROS_SVH
`define CLUSTER_BBOX_CENTROID_FILTER_MACROS_SVH
`ifndef SYNTHESIS
`define CBCF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cbcf assertion failed");
`define CBCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbcf assertion failed");
`else
`define CBCF_ASSERT(label, clk, rst, prop)
`define CBCF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/cbcf_pkg.sv =====
// shared types and constants for the cluster bounding box and centroid filter
// no dependencies
package cbcf_pkg;

  localparam int COORD_BITS   = 18;
  localparam int SUM_BITS     = 30;
  localparam int CNT_BITS     = 13;
  localparam int MAX_POINTS   = 4096;
  localparam int THR_BITS     = 17;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 18;
  localparam int DIV_CNT_BITS = $clog2(SUM_BITS);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;
  typedef logic [THR_BITS-1:0]          thr_t;
  typedef logic [CFG_IDX_BITS-1:0]      cfg_idx_t;
  typedef logic [CFG_DATA_BITS-1:0]     cfg_data_t;
  typedef logic [DIV_CNT_BITS-1:0]      div_cnt_t;

  localparam cfg_idx_t CFG_MAX_HEIGHT   = 3'd0;
  localparam cfg_idx_t CFG_MAX_EXTENT_X = 3'd1;
  localparam cfg_idx_t CFG_MAX_EXTENT_Y = 3'd2;
  localparam cfg_idx_t CFG_FLOOR_LIMIT  = 3'd3;

  localparam thr_t   RST_MAX_HEIGHT   = 17'd400;
  localparam thr_t   RST_MAX_EXTENT   = 17'd500;
  localparam coord_t RST_FLOOR_LIMIT  = '0;

  localparam cnt_t     CNT_LIMIT = CNT_BITS'(MAX_POINTS);
  localparam div_cnt_t DIV_LAST  = DIV_CNT_BITS'(SUM_BITS - 1);

  typedef struct packed {
    logic accum;     // accumulate the accepted point
    logic eval;      // check thresholds, load the dividers
    logic div_step;  // one quotient bit
    logic finish;    // load result register, clear accumulators
  } ctrl_cmd_t;

  typedef struct packed {
    logic keep_now;  // cluster passes all checks (valid during eval)
  } dp_status_t;

endpackage

// ===== rtl/cbcf_point_if.sv =====
// point input channel: valid/ready plus one lidar point
// depends on cbcf_pkg
interface cbcf_point_if import cbcf_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;
  logic   last_of_cluster;

  modport source (output valid, point_x, point_y, point_z, last_of_cluster, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_of_cluster, output ready);
endinterface

// ===== rtl/cbcf_result_if.sv =====
// result output channel: valid/ready plus one cluster result
// depends on cbcf_pkg
interface cbcf_result_if import cbcf_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   kept;
  coord_t center_x;
  coord_t center_y;
  coord_t center_z;

  modport source (output valid, kept, center_x, center_y, center_z, input ready);
  modport sink   (input valid, kept, center_x, center_y, center_z, output ready);
endinterface

// ===== rtl/cbcf_cfg_if.sv =====
// configuration write channel: valid/ready, register index and data
// depends on cbcf_pkg
interface cbcf_cfg_if import cbcf_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/cbcf_dp.sv =====
// datapath: config registers, bounding box and sum accumulators,
// shared-step restoring dividers for the means, result register; uses cbcf_pkg
module cbcf_dp import cbcf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr,
  input  cfg_idx_t   cfg_index,
  input  cfg_data_t  cfg_data,
  input  coord_t     pt_x,
  input  coord_t     pt_y,
  input  coord_t     pt_z,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output logic       res_kept,
  output coord_t     res_x,
  output coord_t     res_y,
  output coord_t     res_z
);

  thr_t   max_height;
  thr_t   max_ext_x;
  thr_t   max_ext_y;
  coord_t floor_limit;

  coord_t min_x, max_x, min_y, max_y, min_z, max_z;
  sum_t   sum_x, sum_y;
  cnt_t   count;

  // divider state
  logic                quo_neg_x, quo_neg_y;
  logic [SUM_BITS-1:0] quo_x, quo_y;
  cnt_t                rem_x, rem_y;
  logic                keep;

  logic signed [SUM_BITS:0] sum_x_wide, sum_y_wide;
  sum_t                     sum_x_next, sum_y_next;
  logic [COORD_BITS:0]      ext_x, ext_y, ext_z;
  logic [CNT_BITS:0]        rem_x_sh, rem_y_sh, divisor;
  logic [SUM_BITS-1:0]      quo_x_fix, quo_y_fix;

  function automatic sum_t sat_sum(input logic signed [SUM_BITS:0] s);
    sum_t r;
    if (s[SUM_BITS] != s[SUM_BITS-1]) begin
      r = s[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      r = s[SUM_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic [SUM_BITS-1:0] magnitude(input sum_t s);
    return s[SUM_BITS-1] ? SUM_BITS'(-s) : SUM_BITS'(s);
  endfunction

  assign sum_x_wide = {sum_x[SUM_BITS-1], sum_x} + (SUM_BITS+1)'(pt_x);
  assign sum_y_wide = {sum_y[SUM_BITS-1], sum_y} + (SUM_BITS+1)'(pt_y);
  assign sum_x_next = sat_sum(sum_x_wide);
  assign sum_y_next = sat_sum(sum_y_wide);

  // extents are non-negative and fit one extra bit
  assign ext_x = {max_x[COORD_BITS-1], max_x} - {min_x[COORD_BITS-1], min_x};
  assign ext_y = {max_y[COORD_BITS-1], max_y} - {min_y[COORD_BITS-1], min_y};
  assign ext_z = {max_z[COORD_BITS-1], max_z} - {min_z[COORD_BITS-1], min_z};

  assign status.keep_now = (ext_z < (COORD_BITS+1)'(max_height)) &&
                           (min_z < floor_limit) &&
                           (ext_x < (COORD_BITS+1)'(max_ext_x)) &&
                           (ext_y < (COORD_BITS+1)'(max_ext_y));

  assign divisor  = {1'b0, count};
  assign rem_x_sh = {rem_x, quo_x[SUM_BITS-1]};
  assign rem_y_sh = {rem_y, quo_y[SUM_BITS-1]};

  assign quo_x_fix = quo_neg_x ? SUM_BITS'(-quo_x) : quo_x;
  assign quo_y_fix = quo_neg_y ? SUM_BITS'(-quo_y) : quo_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_height  <= RST_MAX_HEIGHT;
      max_ext_x   <= RST_MAX_EXTENT;
      max_ext_y   <= RST_MAX_EXTENT;
      floor_limit <= RST_FLOOR_LIMIT;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_MAX_HEIGHT:   max_height  <= cfg_data[THR_BITS-1:0];
        CFG_MAX_EXTENT_X: max_ext_x   <= cfg_data[THR_BITS-1:0];
        CFG_MAX_EXTENT_Y: max_ext_y   <= cfg_data[THR_BITS-1:0];
        CFG_FLOOR_LIMIT:  floor_limit <= cfg_data[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum_x <= '0;
      sum_y <= '0;
    end else if (cmd.finish) begin
      count <= '0;
      sum_x <= '0;
      sum_y <= '0;
    end else if (cmd.accum) begin
      if (count < CNT_LIMIT) begin
        count <= count + 1'b1;
        sum_x <= sum_x_next;
        sum_y <= sum_y_next;
      end
    end
  end

  // first point of a cluster loads the box
  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      if (count == '0) begin
        min_x <= pt_x; max_x <= pt_x;
        min_y <= pt_y; max_y <= pt_y;
        min_z <= pt_z; max_z <= pt_z;
      end else begin
        if (pt_x < min_x) min_x <= pt_x;
        if (pt_x > max_x) max_x <= pt_x;
        if (pt_y < min_y) min_y <= pt_y;
        if (pt_y > max_y) max_y <= pt_y;
        if (pt_z < min_z) min_z <= pt_z;
        if (pt_z > max_z) max_z <= pt_z;
      end
    end
  end

  // restoring division of |sum| by count, one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      keep      <= status.keep_now;
      quo_neg_x <= sum_x[SUM_BITS-1];
      quo_neg_y <= sum_y[SUM_BITS-1];
      quo_x     <= magnitude(sum_x);
      quo_y     <= magnitude(sum_y);
      rem_x     <= '0;
      rem_y     <= '0;
    end else if (cmd.div_step) begin
      if (rem_x_sh >= divisor) begin
        rem_x <= CNT_BITS'(rem_x_sh - divisor);
        quo_x <= {quo_x[SUM_BITS-2:0], 1'b1};
      end else begin
        rem_x <= rem_x_sh[CNT_BITS-1:0];
        quo_x <= {quo_x[SUM_BITS-2:0], 1'b0};
      end
      if (rem_y_sh >= divisor) begin
        rem_y <= CNT_BITS'(rem_y_sh - divisor);
        quo_y <= {quo_y[SUM_BITS-2:0], 1'b1};
      end else begin
        rem_y <= rem_y_sh[CNT_BITS-1:0];
        quo_y <= {quo_y[SUM_BITS-2:0], 1'b0};
      end
    end
  end

  // rejected clusters report zeros
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_kept <= keep;
      res_x    <= keep ? quo_x_fix[COORD_BITS-1:0] : '0;
      res_y    <= keep ? quo_y_fix[COORD_BITS-1:0] : '0;
      res_z    <= keep ? min_z : '0;
    end
  end

endmodule

// ===== rtl/cbcf_ctrl.sv =====
// controller: sequences accumulate, threshold check, divide and result load
// uses cbcf_pkg and the assertion macros header
`include "cluster_bbox_centroid_filter_macros.svh"
module cbcf_ctrl import cbcf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output ctrl_cmd_t  cmd,
  input  dp_status_t status
);

  typedef enum logic [1:0] {S_ACCUM, S_EVAL, S_DIV, S_DONE} state_t;

  state_t   state;
  div_cnt_t step;
  logic     in_fire;
  logic     out_free;

  assign in_ready = (state == S_ACCUM);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.accum    = in_fire;
    cmd.eval     = (state == S_EVAL);
    cmd.div_step = (state == S_DIV);
    cmd.finish   = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACCUM;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_ACCUM: begin
          if (in_fire && in_last) state <= S_EVAL;
        end
        S_EVAL: begin
          step  <= '0;
          state <= status.keep_now ? S_DIV : S_DONE;
        end
        S_DIV: begin
          step <= step + 1'b1;
          if (step == DIV_LAST) state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state <= S_ACCUM;
        end
        default: state <= S_ACCUM;
      endcase
    end
  end

  `CBCF_ASSERT_NEXT(a_last_starts_eval, clk, rst, in_fire && in_last, state == S_EVAL)
  `CBCF_ASSERT_NEXT(a_finish_sets_valid, clk, rst, cmd.finish, out_valid && state == S_ACCUM)
  `CBCF_ASSERT(a_div_step_bound, clk, rst, (state == S_DIV) |-> (step <= DIV_LAST))

endmodule

// ===== rtl/cluster_bbox_centroid_filter.sv =====
// top level of the cluster bounding box and centroid filter
// depends on cbcf_pkg, the channel interfaces, cbcf_ctrl and cbcf_dp
//
//   channel  dir  handshake          beat
//   pt       in   pt.valid/ready     point_x, point_y, point_z, last_of_cluster
//   res      out  res.valid/ready    kept, center_x, center_y, center_z
//   cfg      in   cfg.valid/ready    index, data (register write)
//
// points are taken one per cycle while accumulating; a last point closes
// the cluster. a rejected one then passes the threshold check, a kept one
// also a 30-step shared restoring divider for both means, before the next point.
// the result register holds one beat; the next cluster streams in while it waits.
// rst is synchronous; it restores the threshold defaults and empties the cluster.
// cfg is always ready.
module cluster_bbox_centroid_filter import cbcf_pkg::*; (
  input logic          clk,
  input logic          rst,
  cbcf_point_if.sink   pt,
  cbcf_result_if.source res,
  cbcf_cfg_if.sink     cfg
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg.ready = 1'b1;

  cbcf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pt.valid),
    .in_last   (pt.last_of_cluster),
    .in_ready  (pt.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .cmd       (cmd),
    .status    (status)
  );

  cbcf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .pt_x      (pt.point_x),
    .pt_y      (pt.point_y),
    .pt_z      (pt.point_z),
    .cmd       (cmd),
    .status    (status),
    .res_kept  (res.kept),
    .res_x     (res.center_x),
    .res_y     (res.center_y),
    .res_z     (res.center_z)
  );

endmodule

// ===== sim/cbcf_cluster_checker.sv =====
// cluster checker: watches the point, config and result channels of the filter,
// predicts each cluster result and compares it with the beat that comes out
// depends on cbcf_pkg and the cbcf channel interfaces
module cbcf_cluster_checker import cbcf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  cbcf_point_if  pt,
  cbcf_result_if res,
  cbcf_cfg_if    cfg,
  output int     errors,
  output int     outstanding,
  output int     clusters_seen,
  output int     clusters_kept
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SUM_CEIL  = (longint'(1) <<< (SUM_BITS - 1)) - 1;
  localparam longint SUM_FLOOR = -(longint'(1) <<< (SUM_BITS - 1));

  typedef struct packed {
    logic   kept;
    coord_t center_x;
    coord_t center_y;
    coord_t center_z;
  } cluster_beat_t;

  // threshold copies
  thr_t   height_lim;
  thr_t   ext_x_lim;
  thr_t   ext_y_lim;
  coord_t floor_lim;

  // open cluster
  coord_t lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  sum_t   acc_x, acc_y;
  cnt_t   npts;

  cluster_beat_t pending_clusters[$];
  int mismatches;
  int seen;
  int kept_n;

  function automatic sum_t sat_sum(sum_t acc, coord_t v);
    longint total;
    total = longint'(acc) + longint'(v);
    if (total > SUM_CEIL) total = SUM_CEIL;
    else if (total < SUM_FLOOR) total = SUM_FLOOR;
    return sum_t'(total);
  endfunction

  function automatic void clear_cluster();
    lo_x = '0; hi_x = '0;
    lo_y = '0; hi_y = '0;
    lo_z = '0; hi_z = '0;
    acc_x = '0;
    acc_y = '0;
    npts = '0;
  endfunction

  function automatic void fold_point(coord_t x, coord_t y, coord_t z, logic last);
    cluster_beat_t beat;
    longint span_x, span_y, span_z;
    if (npts == '0) begin
      lo_x = x; hi_x = x;
      lo_y = y; hi_y = y;
      lo_z = z; hi_z = z;
    end else begin
      if (x < lo_x) lo_x = x;
      if (x > hi_x) hi_x = x;
      if (y < lo_y) lo_y = y;
      if (y > hi_y) hi_y = y;
      if (z < lo_z) lo_z = z;
      if (z > hi_z) hi_z = z;
    end
    // past the point limit the box still grows but the sums stay put
    if (npts < CNT_LIMIT) begin
      acc_x = sat_sum(acc_x, x);
      acc_y = sat_sum(acc_y, y);
      npts++;
    end
    if (last) begin
      span_x = longint'(hi_x) - longint'(lo_x);
      span_y = longint'(hi_y) - longint'(lo_y);
      span_z = longint'(hi_z) - longint'(lo_z);
      beat = '0;
      if (span_z < longint'(height_lim) && lo_z < floor_lim &&
          span_x < longint'(ext_x_lim) && span_y < longint'(ext_y_lim)) begin
        beat.kept     = 1'b1;
        beat.center_x = coord_t'(longint'(acc_x) / longint'(npts));
        beat.center_y = coord_t'(longint'(acc_y) / longint'(npts));
        beat.center_z = lo_z;
      end
      pending_clusters = {pending_clusters, beat};
      clear_cluster();
    end
  endfunction

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  initial begin
    mismatches = 0;
    seen = 0;
    kept_n = 0;
  end

  always @(posedge clk) begin : watch
    cluster_beat_t want;
    if (rst) begin
      height_lim = RST_MAX_HEIGHT;
      ext_x_lim = RST_MAX_EXTENT;
      ext_y_lim = RST_MAX_EXTENT;
      floor_lim = RST_FLOOR_LIMIT;
      clear_cluster();
      pending_clusters.delete();
    end else begin
      if (res.valid && res.ready) begin
        seen++;
        if (pending_clusters.size() == 0) begin
          $error("result beat with no closed cluster: kept %0b, center %0d %0d %0d",
                 res.kept, res.center_x, res.center_y, res.center_z);
          mismatches++;
        end else begin
          want = pending_clusters.pop_front();
          if (want.kept) kept_n++;
          check_field("kept", int'(want.kept), int'(res.kept));
          check_field("center_x", int'(want.center_x), int'(res.center_x));
          check_field("center_y", int'(want.center_y), int'(res.center_y));
          check_field("center_z", int'(want.center_z), int'(res.center_z));
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_MAX_HEIGHT:   height_lim = thr_t'(cfg.data);
          CFG_MAX_EXTENT_X: ext_x_lim = thr_t'(cfg.data);
          CFG_MAX_EXTENT_Y: ext_y_lim = thr_t'(cfg.data);
          CFG_FLOOR_LIMIT:  floor_lim = coord_t'(cfg.data);
          default: ;
        endcase
      end
      if (pt.valid && pt.ready)
        fold_point(pt.point_x, pt.point_y, pt.point_z, pt.last_of_cluster);
    end
    errors        <= mismatches;
    outstanding   <= pending_clusters.size();
    clusters_seen <= seen;
    clusters_kept <= kept_n;
  end

endmodule

// ===== sim/tb_cluster_bbox_centroid_filter.sv =====
// testbench top for the cluster bounding box and centroid filter: drives points,
// threshold writes and result backpressure; checking lives in cbcf_cluster_checker
// depends on cbcf_pkg, the cbcf channel interfaces, the filter and the checker
module tb_cluster_bbox_centroid_filter import cbcf_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_HI     = (1 << (COORD_BITS - 1)) - 1;
  localparam int COORD_LO     = -(1 << (COORD_BITS - 1));
  localparam int THR_TOP      = (1 << THR_BITS) - 1;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE       = 40;
  localparam int TAIL         = 64;
  localparam int LONG_CLUSTER = 150;

  logic clk;
  logic rst;

  cbcf_point_if  pt_ch ();
  cbcf_result_if res_ch ();
  cbcf_cfg_if    cfg_ch ();

  int fail_count;
  int outstanding;
  int clusters_seen;
  int clusters_kept;

  int points_sent = 0;
  int settings = 1;
  bit calm = 1'b0;

  // threshold copies, used only to shape the stimulus
  int lim_height = int'(RST_MAX_HEIGHT);
  int lim_ext_x  = int'(RST_MAX_EXTENT);
  int lim_ext_y  = int'(RST_MAX_EXTENT);
  int lim_floor  = int'(RST_FLOOR_LIMIT);

  cluster_bbox_centroid_filter u_dut (
    .clk (clk),
    .rst (rst),
    .pt  (pt_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  cbcf_cluster_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .pt            (pt_ch),
    .res           (res_ch),
    .cfg           (cfg_ch),
    .errors        (fail_count),
    .outstanding   (outstanding),
    .clusters_seen (clusters_seen),
    .clusters_kept (clusters_kept)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int clip(input int v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  function automatic int rand_coord();
    return int'(coord_t'($urandom));
  endfunction

  function automatic int pick_spread(input int thr);
    if ($urandom_range(0, 9) < 7) return (thr > 0) ? int'($urandom_range(0, thr - 1)) : 0;
    return int'($urandom_range(0, thr + 300));
  endfunction

  function automatic int pick_limit();
    if ($urandom_range(0, 4) != 0) return int'($urandom_range(0, 3000));
    return int'($urandom_range(0, THR_TOP));
  endfunction

  task automatic send_point(input int x, input int y, input int z, input bit last);
    if (!calm && $urandom_range(0, 7) == 0) begin
      pt_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    pt_ch.valid           <= 1'b1;
    pt_ch.point_x         <= coord_t'(clip(x));
    pt_ch.point_y         <= coord_t'(clip(y));
    pt_ch.point_z         <= coord_t'(clip(z));
    pt_ch.last_of_cluster <= last;
    do @(posedge clk); while (!pt_ch.ready);
    points_sent++;
  endtask

  // wait for every closed cluster to come out, then let the divider settle
  task automatic drain();
    pt_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= cfg_data_t'(val);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_MAX_HEIGHT:   lim_height = int'(thr_t'(val));
      CFG_MAX_EXTENT_X: lim_ext_x = int'(thr_t'(val));
      CFG_MAX_EXTENT_Y: lim_ext_y = int'(thr_t'(val));
      CFG_FLOOR_LIMIT:  lim_floor = int'(coord_t'(val));
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_limits(input int h, input int ex, input int ey, input int fl);
    write_reg(CFG_MAX_HEIGHT, h);
    write_reg(CFG_MAX_EXTENT_X, ex);
    write_reg(CFG_MAX_EXTENT_Y, ey);
    write_reg(CFG_FLOOR_LIMIT, fl);
    settings++;
  endtask

  task automatic send_cluster(input int n, input int cx, input int cy, input int cz,
                              input int sx, input int sy, input int sz);
    for (int i = 0; i < n; i++)
      send_point(cx + int'($urandom_range(0, sx)), cy + int'($urandom_range(0, sy)),
                 cz + int'($urandom_range(0, sz)), i == n - 1);
  endtask

  // mostly compact clusters near the current window, some scattered noise clusters
  task automatic random_phase(input int n_items);
    int goal, n, pick, sx, sy, sz;
    goal = points_sent + n_items;
    while (points_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) n = $urandom_range(1, 6);
      else if (pick < 96) n = $urandom_range(7, 40);
      else n = $urandom_range(41, 200);
      if ($urandom_range(0, 99) < 85) begin
        sx = pick_spread(lim_ext_x);
        sy = pick_spread(lim_ext_y);
        sz = pick_spread(lim_height);
        send_cluster(n, rand_coord(), rand_coord(),
                     lim_floor - int'($urandom_range(1, sz + 600)), sx, sy, sz);
      end else begin
        for (int i = 0; i < n; i++)
          send_point(rand_coord(), rand_coord(), rand_coord(), i == n - 1);
      end
    end
    drain();
  endtask

  // result side backpressure in random bursts
  initial begin : result_sink
    int stall;
    stall = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall == 0 && !calm && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 13);
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        stall--;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_cluster_bbox_centroid_filter: errors");
    $finish;
  end

  initial begin : stimulus
    rst                   <= 1'b1;
    pt_ch.valid           <= 1'b0;
    pt_ch.point_x         <= '0;
    pt_ch.point_y         <= '0;
    pt_ch.point_z         <= '0;
    pt_ch.last_of_cluster <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= CFG_MAX_HEIGHT;
    cfg_ch.data           <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset thresholds: single points, floor boundary, coordinate extremes
    send_point(0, 0, -1, 1);
    send_point(5, 5, 0, 1);
    send_point(COORD_LO, COORD_HI, COORD_LO, 1);
    send_point(COORD_HI, COORD_LO, -1, 1);
    // height one under and at the limit; negative mean truncates toward zero
    send_point(-3, 10, -500, 0);
    send_point(-2, 11, -101, 1);
    send_point(0, 0, -500, 0);
    send_point(0, 0, -100, 1);
    // x and y extents one under and at the limit
    send_point(100, 0, -10, 0);
    send_point(599, 0, -10, 1);
    send_point(100, 0, -10, 0);
    send_point(600, 0, -10, 1);
    send_point(0, 100, -10, 0);
    send_point(0, 599, -10, 1);
    send_point(0, 100, -10, 0);
    send_point(0, 600, -10, 1);
    send_point(-7, 7, -2, 0);
    send_point(2, -2, -3, 0);
    send_point(1, 0, -4, 1);
    drain();

    // writes to indexes past the last register must change nothing
    for (int i = int'(CFG_FLOOR_LIMIT) + 1; i < (1 << CFG_IDX_BITS); i++)
      write_reg(cfg_idx_t'(i), $urandom);

    // widest window: a long cluster at the coordinate extremes, large sums
    set_limits(THR_TOP, THR_TOP, THR_TOP, COORD_HI);
    for (int i = 0; i < LONG_CLUSTER; i++)
      send_point(COORD_LO, COORD_HI, COORD_LO + int'($urandom_range(0, 1000)), 1'b0);
    for (int i = 0; i < 4; i++)
      send_point(-1000, 1000, COORD_LO, i == 3);
    // full-span extent must not wrap
    send_point(COORD_LO, 0, -5, 0);
    send_point(COORD_HI, 0, -5, 1);
    random_phase(100);

    // zero thresholds and lowest floor reject everything
    set_limits(0, 0, 0, COORD_LO);
    random_phase(60);

    for (int p = 0; p < 5; p++) begin
      if (p == 4) calm = 1'b1;
      set_limits(pick_limit(), pick_limit(), pick_limit(),
                 ($urandom_range(0, 4) != 0) ? int'($urandom_range(0, 10000)) - 5000
                                             : rand_coord());
      random_phase(120);
    end

    repeat (TAIL) @(posedge clk);
    $display("covered %0d points, %0d clusters checked (%0d kept) over %0d threshold settings",
             points_sent, clusters_seen, clusters_kept, settings);
    if (fail_count == 0)
      $display("tb_cluster_bbox_centroid_filter: clean");
    else
      $display("tb_cluster_bbox_centroid_filter: errors");
    $finish;
  end

endmodule

// ===== cluster_bbox_centroid_filter.f =====
+incdir+rtl
rtl/cbcf_pkg.sv
rtl/cbcf_point_if.sv
rtl/cbcf_result_if.sv
rtl/cbcf_cfg_if.sv
rtl/cbcf_dp.sv
rtl/cbcf_ctrl.sv
rtl/cluster_bbox_centroid_filter.sv
sim/cbcf_cluster_checker.sv
sim/tb_cluster_bbox_centroid_filter.sv
